[src/msgpk_pkg.sv]
// Shared definitions for the MessagePack token encoder: token kinds, tag bytes
// and the encoded-token record passed from the encoder core to the top level.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package msgpk_pkg;

  typedef enum logic [3:0] {
    OP_SINT   = 4'd0,
    OP_UINT   = 4'd1,
    OP_BOOL   = 4'd2,
    OP_DOUBLE = 4'd3,
    OP_STR    = 4'd4,
    OP_BIN    = 4'd5,
    OP_ARRAY  = 4'd6,
    OP_MAP    = 4'd7,
    OP_BYTE   = 4'd8
  } op_e;

  localparam logic [7:0] TAG_FIXMAP   = 8'h80;
  localparam logic [7:0] TAG_FIXARRAY = 8'h90;
  localparam logic [7:0] TAG_FIXSTR   = 8'ha0;
  localparam logic [7:0] TAG_FALSE    = 8'hc2;
  localparam logic [7:0] TAG_TRUE     = 8'hc3;
  localparam logic [7:0] TAG_BIN8     = 8'hc4;
  localparam logic [7:0] TAG_BIN16    = 8'hc5;
  localparam logic [7:0] TAG_BIN32    = 8'hc6;
  localparam logic [7:0] TAG_FLOAT64  = 8'hcb;
  localparam logic [7:0] TAG_UINT8    = 8'hcc;
  localparam logic [7:0] TAG_UINT16   = 8'hcd;
  localparam logic [7:0] TAG_UINT32   = 8'hce;
  localparam logic [7:0] TAG_UINT64   = 8'hcf;
  localparam logic [7:0] TAG_INT8     = 8'hd0;
  localparam logic [7:0] TAG_INT16    = 8'hd1;
  localparam logic [7:0] TAG_INT32    = 8'hd2;
  localparam logic [7:0] TAG_INT64    = 8'hd3;
  localparam logic [7:0] TAG_STR8     = 8'hd9;
  localparam logic [7:0] TAG_STR16    = 8'hda;
  localparam logic [7:0] TAG_STR32    = 8'hdb;
  localparam logic [7:0] TAG_ARRAY16  = 8'hdc;
  localparam logic [7:0] TAG_ARRAY32  = 8'hdd;
  localparam logic [7:0] TAG_MAP16    = 8'hde;
  localparam logic [7:0] TAG_MAP32    = 8'hdf;

  // Longest encoding: one tag byte and eight operand bytes.
  localparam int unsigned MaxBytes = 9;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);

  // One encoded token: tag byte, operand bytes left aligned (first byte in
  // bits 63:56), and the total byte count (zero for an unknown kind).
  typedef struct packed {
    logic [7:0]      tag;
    logic [63:0]     data;
    logic [CntW-1:0] count;
  } enc_t;

endpackage

`default_nettype wire

[src/msgpk_enc.sv]
// Combinational encoder core: picks the smallest MessagePack form for one
// token, except that signed values above 2^31-1 take int64, and returns
// its tag, aligned operand bytes and byte count. Depends on msgpk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msgpk_enc (
  input  wire logic [3:0]       op_i,
  input  wire logic [63:0]      value_i,
  output msgpk_pkg::enc_t       enc_o
);

  logic [31:0]                    len32;
  logic                           use_len;
  logic [63:0]                    src;
  logic [7:0]                     tag;
  logic [msgpk_pkg::CntW-1:0]     nb;
  logic                           known;
  logic [63:0]                    data;

  // Header lengths saturate to 32 bits.
  assign len32 = (|value_i[63:32]) ? 32'hffff_ffff : value_i[31:0];

  always_comb begin
    tag     = value_i[7:0];
    nb      = '0;
    known   = 1'b1;
    use_len = 1'b0;
    unique case (op_i)
      msgpk_pkg::OP_SINT: begin
        if (!value_i[63]) begin
          if (value_i[63:7] == '0) begin
            tag = value_i[7:0];
          end else if (value_i[63:8] == '0) begin
            tag = msgpk_pkg::TAG_UINT8;  nb = 4'd1;
          end else if (value_i[63:16] == '0) begin
            tag = msgpk_pkg::TAG_UINT16; nb = 4'd2;
          end else if (value_i[63:31] == '0) begin
            tag = msgpk_pkg::TAG_UINT32; nb = 4'd4;
          end else begin
            tag = msgpk_pkg::TAG_INT64;  nb = 4'd8;
          end
        end else begin
          if (&value_i[63:5]) begin
            tag = value_i[7:0];
          end else if (&value_i[63:7]) begin
            tag = msgpk_pkg::TAG_INT8;  nb = 4'd1;
          end else if (&value_i[63:15]) begin
            tag = msgpk_pkg::TAG_INT16; nb = 4'd2;
          end else if (&value_i[63:31]) begin
            tag = msgpk_pkg::TAG_INT32; nb = 4'd4;
          end else begin
            tag = msgpk_pkg::TAG_INT64; nb = 4'd8;
          end
        end
      end
      msgpk_pkg::OP_UINT: begin
        if (value_i[63:7] == '0) begin
          tag = value_i[7:0];
        end else if (value_i[63:8] == '0) begin
          tag = msgpk_pkg::TAG_UINT8;  nb = 4'd1;
        end else if (value_i[63:16] == '0) begin
          tag = msgpk_pkg::TAG_UINT16; nb = 4'd2;
        end else if (value_i[63:32] == '0) begin
          tag = msgpk_pkg::TAG_UINT32; nb = 4'd4;
        end else begin
          tag = msgpk_pkg::TAG_UINT64; nb = 4'd8;
        end
      end
      msgpk_pkg::OP_BOOL: begin
        tag = (|value_i) ? msgpk_pkg::TAG_TRUE : msgpk_pkg::TAG_FALSE;
      end
      msgpk_pkg::OP_DOUBLE: begin
        tag = msgpk_pkg::TAG_FLOAT64; nb = 4'd8;
      end
      msgpk_pkg::OP_STR: begin
        use_len = 1'b1;
        if (len32 <= 32'd31) begin
          tag = msgpk_pkg::TAG_FIXSTR | {3'b000, len32[4:0]};
        end else if (len32 <= 32'd255) begin
          tag = msgpk_pkg::TAG_STR8;  nb = 4'd1;
        end else if (len32 <= 32'd65535) begin
          tag = msgpk_pkg::TAG_STR16; nb = 4'd2;
        end else begin
          tag = msgpk_pkg::TAG_STR32; nb = 4'd4;
        end
      end
      msgpk_pkg::OP_BIN: begin
        use_len = 1'b1;
        if (len32 <= 32'd255) begin
          tag = msgpk_pkg::TAG_BIN8;  nb = 4'd1;
        end else if (len32 <= 32'd65535) begin
          tag = msgpk_pkg::TAG_BIN16; nb = 4'd2;
        end else begin
          tag = msgpk_pkg::TAG_BIN32; nb = 4'd4;
        end
      end
      msgpk_pkg::OP_ARRAY: begin
        use_len = 1'b1;
        if (len32 <= 32'd15) begin
          tag = msgpk_pkg::TAG_FIXARRAY | {4'b0000, len32[3:0]};
        end else if (len32 <= 32'd65535) begin
          tag = msgpk_pkg::TAG_ARRAY16; nb = 4'd2;
        end else begin
          tag = msgpk_pkg::TAG_ARRAY32; nb = 4'd4;
        end
      end
      msgpk_pkg::OP_MAP: begin
        use_len = 1'b1;
        if (len32 <= 32'd15) begin
          tag = msgpk_pkg::TAG_FIXMAP | {4'b0000, len32[3:0]};
        end else if (len32 <= 32'd65535) begin
          tag = msgpk_pkg::TAG_MAP16; nb = 4'd2;
        end else begin
          tag = msgpk_pkg::TAG_MAP32; nb = 4'd4;
        end
      end
      msgpk_pkg::OP_BYTE: begin
        tag = value_i[7:0];
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign src = use_len ? {32'd0, len32} : value_i;

  // Operand bytes go out big-endian, so the low bytes move to the top.
  always_comb begin
    unique case (nb)
      4'd1:    data = {src[7:0], 56'd0};
      4'd2:    data = {src[15:0], 48'd0};
      4'd4:    data = {src[31:0], 32'd0};
      4'd8:    data = src;
      default: data = '0;
    endcase
  end

  assign enc_o.tag   = tag;
  assign enc_o.data  = data;
  assign enc_o.count = known ? nb + 4'd1 : '0;

endmodule

`default_nettype wire

[src/msgpack_token_encoder.sv]
// Top level of the MessagePack token encoder: token input register, encoder
// core and a byte shift register that streams the encoding out.
// Depends on msgpk_pkg and msgpk_enc.
//
//   Channel   Handshake               Payload
//   -------   ---------------------   -----------------------------
//   token     start / busy            op_i[3:0], value_i[63:0]
//   byte      out_valid_o (strobe)    out_byte_o[7:0], last_o
//
// A token is taken at a clock edge where start is high and busy is low. It
// waits in the input register, is encoded and loaded into the byte shift
// register, and its bytes then leave one per cycle (an encoding has one to
// nine bytes); an unknown kind produces no byte. The byte shift register
// sets that pace. busy is high only while a waiting token cannot yet move
// into the shift register, so the next token is taken while the current one
// still streams. The byte side cannot stall. Reset clears the valid flag and
// byte count.
`timescale 1ns / 1ps
`default_nettype none

module msgpack_token_encoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [3:0]  op_i,
  input  wire logic [63:0] value_i,
  output      logic        out_valid_o,
  output      logic [7:0]  out_byte_o,
  output      logic        last_o
);

  // Input register holding one accepted token.
  logic        in_valid_q, in_valid_d;
  logic [3:0]  op_q;
  logic [63:0] value_q;

  // Shift register: next byte to send sits in the top eight bits.
  logic [71:0]                    shift_q, shift_d;
  logic [msgpk_pkg::CntW-1:0]     rem_q, rem_d;

  msgpk_pkg::enc_t enc;
  logic            accept;
  logic            load;

  msgpk_enc u_enc (
    .op_i    (op_q),
    .value_i (value_q),
    .enc_o   (enc)
  );

  // The waiting token moves on when the shift register is empty or is
  // sending its final byte in this cycle.
  assign load   = in_valid_q && (rem_q <= 4'd1);
  assign busy   = in_valid_q && !load;
  assign accept = start && !busy;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (load) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    shift_d = shift_q;
    rem_d   = rem_q;
    if (load) begin
      shift_d = {enc.tag, enc.data};
      rem_d   = enc.count;
    end else if (rem_q != '0) begin
      shift_d = {shift_q[63:0], 8'd0};
      rem_d   = rem_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      rem_q      <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      rem_q      <= rem_d;
    end
  end

  // Payload registers carry no reset; the valid flag and count guard them.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_i;
      value_q <= value_i;
    end
    shift_q <= shift_d;
  end

  assign out_valid_o = (rem_q != '0);
  assign out_byte_o  = shift_q[71:64];
  assign last_o      = (rem_q == 4'd1);

`ifndef NO_ASSERTIONS
  // A token's bytes leave without gaps until the final one.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |=> out_valid_o)
    else $error("byte stream broke before the final byte");

  // An accepted token always lands in the input register.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> in_valid_q)
    else $error("accepted token was not captured");

  // The byte count never exceeds the longest encoding.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= 4'd9)
    else $error("byte count out of range");

  // While busy, the held token must stay unchanged.
  a_hold_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> $stable(op_q) && $stable(value_q))
    else $error("waiting token changed while busy");
`endif

endmodule

`default_nettype wire

[bench/msgpack_token_checker.sv]
// Checker for the MessagePack token encoder: watches the token and byte channels,
// predicts each token's encoded bytes and compares them word by word.
// Depends on msgpk_pkg for the token kinds and tag bytes.
`timescale 1ns / 1ps

module msgpack_token_checker
  import msgpk_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [3:0]        op_i,
  input  logic [63:0]       value_i,
  input  logic              out_valid_i,
  input  logic [7:0]        out_byte_i,
  input  logic              last_i,
  output int unsigned       mismatches_o,
  output int unsigned       pending_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_word_t;

  byte_word_t  encoded_bytes[$];
  int unsigned errors = 0;

  // Works out the encoding of one token and appends its bytes to the queue.
  task automatic queue_encoding(input logic [3:0] op, input logic [63:0] value);
    logic [7:0]  tag;
    logic [63:0] operand;
    logic [63:0] mag;
    logic [63:0] len;
    int          n_operand;
    bit          known;
    int          k;
    known     = 1'b1;
    operand   = value;
    n_operand = 0;
    tag       = value[7:0];
    mag       = -value;
    len       = (value > 64'hffff_ffff) ? 64'hffff_ffff : value;
    case (op)
      OP_SINT: begin
        if (!value[63]) begin
          if (value <= 64'd127) begin
            tag = value[7:0];
          end else if (value <= 64'hff) begin
            tag = TAG_UINT8; n_operand = 1;
          end else if (value <= 64'hffff) begin
            tag = TAG_UINT16; n_operand = 2;
          end else if (value <= 64'h7fff_ffff) begin
            tag = TAG_UINT32; n_operand = 4;
          end else begin
            tag = TAG_INT64; n_operand = 8;
          end
        end else begin
          if (mag <= 64'd32) begin
            tag = value[7:0];
          end else if (mag <= 64'd128) begin
            tag = TAG_INT8; n_operand = 1;
          end else if (mag <= 64'd32768) begin
            tag = TAG_INT16; n_operand = 2;
          end else if (mag <= 64'h8000_0000) begin
            tag = TAG_INT32; n_operand = 4;
          end else begin
            tag = TAG_INT64; n_operand = 8;
          end
        end
      end
      OP_UINT: begin
        if (value <= 64'd127) begin
          tag = value[7:0];
        end else if (value <= 64'hff) begin
          tag = TAG_UINT8; n_operand = 1;
        end else if (value <= 64'hffff) begin
          tag = TAG_UINT16; n_operand = 2;
        end else if (value <= 64'hffff_ffff) begin
          tag = TAG_UINT32; n_operand = 4;
        end else begin
          tag = TAG_UINT64; n_operand = 8;
        end
      end
      OP_BOOL: begin
        tag = (value != 64'd0) ? TAG_TRUE : TAG_FALSE;
      end
      OP_DOUBLE: begin
        tag = TAG_FLOAT64; n_operand = 8;
      end
      OP_STR: begin
        operand = len;
        if (len <= 64'd31) begin
          tag = TAG_FIXSTR | len[7:0];
        end else if (len <= 64'hff) begin
          tag = TAG_STR8; n_operand = 1;
        end else if (len <= 64'hffff) begin
          tag = TAG_STR16; n_operand = 2;
        end else begin
          tag = TAG_STR32; n_operand = 4;
        end
      end
      OP_BIN: begin
        operand = len;
        if (len <= 64'hff) begin
          tag = TAG_BIN8; n_operand = 1;
        end else if (len <= 64'hffff) begin
          tag = TAG_BIN16; n_operand = 2;
        end else begin
          tag = TAG_BIN32; n_operand = 4;
        end
      end
      OP_ARRAY, OP_MAP: begin
        operand = len;
        if (len <= 64'd15) begin
          tag = ((op == OP_ARRAY) ? TAG_FIXARRAY : TAG_FIXMAP) | len[7:0];
        end else if (len <= 64'hffff) begin
          tag = (op == OP_ARRAY) ? TAG_ARRAY16 : TAG_MAP16;
          n_operand = 2;
        end else begin
          tag = (op == OP_ARRAY) ? TAG_ARRAY32 : TAG_MAP32;
          n_operand = 4;
        end
      end
      OP_BYTE: begin
        tag = value[7:0];
      end
      default: begin
        known = 1'b0;
      end
    endcase
    if (known) begin
      encoded_bytes.push_back('{data: tag, last: (n_operand == 0)});
      for (k = n_operand - 1; k >= 0; k--) begin
        encoded_bytes.push_back('{data: operand[8*k +: 8], last: (k == 0)});
      end
    end
  endtask

  // Sampled at the rising edge, so both channels are seen with their pre-edge values.
  always @(posedge clk_i or negedge rst_ni) begin
    byte_word_t want;
    if (!rst_ni) begin
      encoded_bytes.delete();
      pending_o    <= 0;
      mismatches_o <= errors;
    end else begin
      if (start_i && !busy_i) begin
        queue_encoding(op_i, value_i);
      end
      if (out_valid_i) begin
        if (encoded_bytes.size() == 0) begin
          $error("out_byte: no byte expected, got %h (last %b)", out_byte_i, last_i);
          errors++;
        end else begin
          want = encoded_bytes.pop_front();
          if (out_byte_i !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, out_byte_i);
            errors++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %b, got %b", want.last, last_i);
            errors++;
          end
        end
      end
      pending_o    <= encoded_bytes.size();
      mismatches_o <= errors;
    end
  end

endmodule

[bench/testbench.sv]
// Top of the MessagePack token encoder bench: clock, reset, token stimulus and
// the final verdict. Depends on msgpk_pkg, msgpack_token_encoder and
// msgpack_token_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module testbench;

  import msgpk_pkg::*;

  // Kinds the block does not know; such a token must produce no byte at all.
  localparam logic [3:0] OpUnusedLo = 4'd9;
  localparam logic [3:0] OpUnusedHi = 4'd15;

  // Tokens to send in the whole run, and quiet cycles left at the end so a
  // spurious byte has time to show up.
  localparam int unsigned TokenTarget = 170;
  localparam int unsigned TailCycles  = 20;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [3:0]  op;
  logic [63:0] value;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        last;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned tokens_sent = 0;
  bit          no_idle     = 1'b0;

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  msgpack_token_encoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .op_i        (op),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_byte_o  (out_byte),
    .last_o      (last)
  );

  msgpack_token_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .op_i         (op),
    .value_i      (value),
    .out_valid_i  (out_valid),
    .out_byte_i   (out_byte),
    .last_i       (last),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Offers one token and returns at the edge that takes it. The idle gap is
  // drawn per word; when no_idle is set the token follows its predecessor
  // back to back, and start simply stays high.
  task automatic send_token(input logic [3:0] kind, input logic [63:0] operand);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op    <= kind;
    value <= operand;
    do @(posedge clk); while (busy);
    tokens_sent++;
  endtask

  // Holds the token side off until every predicted byte has come out. The
  // checker's count is registered, so the loop waits on an edge before it looks.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Magnitudes that favor the form boundaries of the encoding: either right at
  // a boundary (plus or minus one), a random value of random width, or fully
  // random 64 bits.
  function automatic logic [63:0] rand_magnitude();
    logic [63:0] borders[14];
    borders = '{64'd15, 64'd16, 64'd31, 64'd32, 64'd127, 64'd128, 64'd255,
                64'd256, 64'hffff, 64'h1_0000, 64'h7fff_ffff, 64'h8000_0000,
                64'hffff_ffff, 64'h1_0000_0000};
    case ($urandom_range(0, 2))
      0:       return borders[$urandom_range(0, 13)] + $urandom_range(0, 2) - 64'd1;
      1:       return rand64() >> $urandom_range(0, 63);
      default: return rand64();
    endcase
  endfunction

  // One scalar token with random content, as it would sit inside a container.
  task automatic send_scalar();
    logic [63:0] v;
    v = rand_magnitude();
    case ($urandom_range(0, 3))
      0:       send_token(OP_SINT, $urandom_range(0, 1) ? -v : v);
      1:       send_token(OP_UINT, v);
      2:       send_token(OP_BOOL, $urandom_range(0, 1) ? rand64() : 64'd0);
      default: send_token(OP_DOUBLE, rand64());
    endcase
  endtask

  // Hard stop in case the block hangs, set far beyond the slowest correct run.
  initial begin
    #2ms;
    $display("msgpack_token_encoder regression: fail");
    $finish;
  end

  initial begin
    int unsigned next_drain;
    int unsigned count;
    int unsigned i;
    logic [3:0]  hdr;

    start <= 1'b0;
    op    <= OP_SINT;
    value <= 64'd0;
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: the form boundaries of the integer encodings, both
    // booleans, a double, header boundaries, length saturation, a payload byte
    // with junk in its upper bits, and unknown kinds.
    send_token(OP_SINT, 64'd0);
    send_token(OP_SINT, 64'd127);
    send_token(OP_SINT, -64'd32);
    send_token(OP_SINT, -64'd33);
    send_token(OP_SINT, -64'd128);
    send_token(OP_SINT, -64'd129);
    send_token(OP_SINT, 64'h7fff_ffff);
    send_token(OP_SINT, -64'h8000_0000);
    send_token(OP_SINT, 64'h8000_0000_0000_0000);
    send_token(OP_SINT, 64'h7fff_ffff_ffff_ffff);
    send_token(OP_UINT, 64'd128);
    send_token(OP_UINT, 64'hffff_ffff);
    send_token(OP_UINT, 64'hffff_ffff_ffff_ffff);
    send_token(OP_BOOL, 64'd0);
    send_token(OP_BOOL, 64'h8000_0000_0000_0000);
    send_token(OP_DOUBLE, 64'h0123_4567_89ab_cdef);
    send_token(OP_STR, 64'd31);
    send_token(OP_STR, 64'd32);
    send_token(OP_BIN, 64'd0);
    send_token(OP_ARRAY, 64'd16);
    send_token(OP_MAP, 64'hffff_ffff_ffff);
    send_token(OP_BYTE, 64'hffff_ffff_ffff_ffa5);
    send_token(OpUnusedLo, 64'hffff_ffff_ffff_ffff);
    send_token(OpUnusedHi, 64'd1);
    send_token(OP_STR, 64'd0);
    wait_drained();

    // Random part. Most traffic is well-formed: string and binary headers
    // followed by their payload bytes, and containers followed by their
    // elements. The rest is lone scalars, headers with wide lengths, and noise.
    next_drain = tokens_sent + 50;
    while (tokens_sent < TokenTarget) begin
      // Switch now and then between drawn gaps and back-to-back stretches.
      if ($urandom_range(0, 5) == 0) begin
        no_idle = !no_idle;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          hdr   = $urandom_range(0, 1) ? OP_STR : OP_BIN;
          count = $urandom_range(0, 12);
          send_token(hdr, 64'(count));
          for (i = 0; i < count; i++) begin
            send_token(OP_BYTE, rand64());
          end
        end
        3: begin
          hdr   = $urandom_range(0, 1) ? OP_ARRAY : OP_MAP;
          count = $urandom_range(0, 4);
          send_token(hdr, 64'(count));
          for (i = 0; i < ((hdr == OP_MAP) ? 2 * count : count); i++) begin
            send_scalar();
          end
        end
        4, 5, 6: begin
          send_scalar();
        end
        7, 8: begin
          send_token(4'($urandom_range(OP_STR, OP_MAP)), rand_magnitude());
        end
        default: begin
          send_token(4'($urandom_range(0, 15)), rand64());
        end
      endcase
      if (tokens_sent >= next_drain) begin
        wait_drained();
        next_drain = tokens_sent + 50;
      end
    end

    // Let everything drain, then give a spurious byte time to show up.
    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("msgpack_token_encoder regression: pass");
    end else begin
      $display("msgpack_token_encoder regression: fail");
    end
    $finish;
  end

endmodule
